FILE: rtl/core/fwcp_pkg.sv
// Shared types and constants of the fixed-width code packer.
// No dependencies; every other file of the block refers to it by scoped names.
package fwcp_pkg;

    localparam int CODE_W         = 32;
    localparam int MAX_CODE_WIDTH = 32;
    localparam int WIDTH_W        = 6;
    localparam int BYTE_W         = 8;
    localparam int PEND_W         = 7;
    localparam int PCOUNT_W       = 3;
    localparam int ACC_W          = 40;
    localparam int TOTAL_W        = 6;
    localparam int NBYTES_W       = 3;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = 1;
    localparam int QCOUNT_W       = 2;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(12);
    localparam logic [WIDTH_W-1:0] WIDTH_LIMIT =
        (MAX_CODE_WIDTH < CODE_W) ? WIDTH_W'(MAX_CODE_WIDTH) : WIDTH_W'(CODE_W);

    typedef struct packed {
        logic [ACC_W-1:0]    bits;
        logic [NBYTES_W-1:0] n_bytes;
        logic                fin;
    } job_t;

endpackage

FILE: rtl/core/fwcp_front.sv
// Front end of the code packer: width register, pending-bit state and job build.
// Depends on fwcp_pkg for the job type and widths.
module fwcp_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [fwcp_pkg::WIDTH_W-1:0]    cfg_data,
    input  logic                            item_fire,
    input  logic [fwcp_pkg::CODE_W-1:0]     code,
    input  logic                            final_code,
    output fwcp_pkg::job_t                  job,
    output logic                            job_push
);

    logic [fwcp_pkg::WIDTH_W-1:0]   width_reg;
    logic [fwcp_pkg::WIDTH_W-1:0]   width_next;
    logic [fwcp_pkg::PEND_W-1:0]    pend_bits_reg;
    logic [fwcp_pkg::PEND_W-1:0]    pend_bits_next;
    logic [fwcp_pkg::PCOUNT_W-1:0]  pend_count_reg;
    logic [fwcp_pkg::PCOUNT_W-1:0]  pend_count_next;

    logic [fwcp_pkg::WIDTH_W-1:0]   eff_width;
    logic [fwcp_pkg::CODE_W:0]      code_mask;
    logic [fwcp_pkg::CODE_W-1:0]    code_m;
    logic [fwcp_pkg::ACC_W-1:0]     acc;
    logic [fwcp_pkg::TOTAL_W-1:0]   total;
    logic [fwcp_pkg::TOTAL_W-1:0]   align_shift;
    logic                           flush_byte;
    logic [fwcp_pkg::PEND_W-1:0]    rem_mask;

    assign eff_width  = (width_reg > fwcp_pkg::WIDTH_LIMIT) ? fwcp_pkg::WIDTH_LIMIT : width_reg;
    assign code_mask  = ~({(fwcp_pkg::CODE_W+1){1'b1}} << eff_width);
    assign code_m     = code & code_mask[fwcp_pkg::CODE_W-1:0];

    assign acc = ({{(fwcp_pkg::ACC_W-fwcp_pkg::PEND_W){1'b0}}, pend_bits_reg} << eff_width)
               | {{(fwcp_pkg::ACC_W-fwcp_pkg::CODE_W){1'b0}}, code_m};
    assign total       = {{(fwcp_pkg::TOTAL_W-fwcp_pkg::PCOUNT_W){1'b0}}, pend_count_reg}
                       + eff_width;
    assign align_shift = fwcp_pkg::TOTAL_W'(fwcp_pkg::ACC_W) - total;
    assign flush_byte  = final_code && (total[2:0] != 3'd0);
    assign rem_mask    = ~({fwcp_pkg::PEND_W{1'b1}} << total[2:0]);

    always_comb
    begin
        job.bits    = acc << align_shift;
        job.n_bytes = total[fwcp_pkg::TOTAL_W-1:3]
                    + {{(fwcp_pkg::NBYTES_W-1){1'b0}}, flush_byte};
        job.fin     = final_code;
    end

    assign job_push = item_fire && (job.n_bytes != '0);

    always_comb
    begin
        width_next      = width_reg;
        pend_bits_next  = pend_bits_reg;
        pend_count_next = pend_count_reg;
        if (cfg_valid)
        begin
            width_next = cfg_data;
        end
        if (item_fire)
        begin
            if (final_code)
            begin
                pend_bits_next  = '0;
                pend_count_next = '0;
            end
            else
            begin
                pend_bits_next  = acc[fwcp_pkg::PEND_W-1:0] & rem_mask;
                pend_count_next = total[2:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= fwcp_pkg::WIDTH_RESET;
            pend_bits_reg  <= '0;
            pend_count_reg <= '0;
        end
        else
        begin
            width_reg      <= width_next;
            pend_bits_reg  <= pend_bits_next;
            pend_count_reg <= pend_count_next;
        end
    end

endmodule

FILE: rtl/core/fwcp_queue.sv
// Two-entry job queue between the front end and the byte emitter.
// Depends on fwcp_pkg for the job type and queue sizes.
module fwcp_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fwcp_pkg::job_t  push_job,
    input  logic            pop,
    output fwcp_pkg::job_t  head,
    output logic            empty,
    output logic            full
);

    fwcp_pkg::job_t                 entries [fwcp_pkg::QUEUE_DEPTH];
    logic [fwcp_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [fwcp_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [fwcp_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [fwcp_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [fwcp_pkg::QCOUNT_W-1:0]  count_reg;
    logic [fwcp_pkg::QCOUNT_W-1:0]  count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == fwcp_pkg::QCOUNT_W'(fwcp_pkg::QUEUE_DEPTH));
    assign head  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/fwcp_back.sv
// Byte emitter: walks the head job into the output register one byte a cycle unless stalled.
// Depends on fwcp_pkg for the job type and widths.
module fwcp_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  fwcp_pkg::job_t                  head,
    input  logic                            empty,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [fwcp_pkg::BYTE_W-1:0]     packed_byte,
    output logic                            run_end,
    output logic                            stream_end
);

    logic [fwcp_pkg::NBYTES_W-1:0]  idx_reg;
    logic [fwcp_pkg::NBYTES_W-1:0]  idx_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [fwcp_pkg::BYTE_W-1:0]    byte_reg;
    logic                           run_end_reg;
    logic                           stream_end_reg;

    logic                           load;
    logic                           last_byte;
    logic [fwcp_pkg::ACC_W-1:0]     shifted;

    assign load      = !empty && (!out_valid_reg || !out_stall);
    assign last_byte = (idx_reg == head.n_bytes - 1'b1);
    assign shifted   = head.bits << {idx_reg, 3'b000};
    assign pop       = load && last_byte;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = last_byte ? '0 : idx_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg       <= shifted[fwcp_pkg::ACC_W-1 -: fwcp_pkg::BYTE_W];
            run_end_reg    <= last_byte;
            stream_end_reg <= last_byte && head.fin;
        end
    end

    assign out_valid   = out_valid_reg;
    assign packed_byte = byte_reg;
    assign run_end     = run_end_reg;
    assign stream_end  = stream_end_reg;

`ifndef SYNTHESIS
    a_stream_end_on_run_end : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && stream_end_reg |-> run_end_reg)
        else $error("stream end flagged on a byte that does not close its request");

    a_idx_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (idx_reg < head.n_bytes))
        else $error("byte index beyond the head job");

    a_idle_idx_zero : assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> (idx_reg == '0))
        else $error("byte index not rewound with no job queued");

    a_pop_advances : assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg && $past(last_byte))
        else $error("job dropped without its last byte loaded");
`endif

endmodule

FILE: rtl/core/fixed_width_code_packer_unit.sv
// Top level of the fixed-width code packer: front end, job queue and byte emitter.
// Depends on fwcp_pkg, fwcp_front, fwcp_queue and fwcp_back.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  cfg      | cfg_valid, cfg_ready  | code_width
//  in       | in_valid, in_stall    | code, final_code
//  out      | out_valid, out_stall  | packed_byte, run_end, stream_end
//
// One request enters per cycle while the two-entry job queue has room.
// The byte output register sets the pace, one byte of a code at a time; a code yields
// up to 5 bytes with a flush, four for a 32-bit width unless a flush adds a fifth.
// First byte of a request passes through the job queue and then the output register.
// Reset clears width to 12, pending bits, queue and output valid.
// out_stall holds the output byte; in_stall rises only with the queue full.
module fixed_width_code_packer_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fwcp_pkg::WIDTH_W-1:0]    code_width,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [fwcp_pkg::CODE_W-1:0]     code,
    input  logic                            final_code,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [fwcp_pkg::BYTE_W-1:0]     packed_byte,
    output logic                            run_end,
    output logic                            stream_end
);

    fwcp_pkg::job_t new_job;
    fwcp_pkg::job_t head_job;
    logic           job_push;
    logic           job_pop;
    logic           q_empty;
    logic           q_full;
    logic           item_fire;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign item_fire = in_valid && !q_full;

    fwcp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (code_width),
        .item_fire  (item_fire),
        .code       (code),
        .final_code (final_code),
        .job        (new_job),
        .job_push   (job_push)
    );

    fwcp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (new_job),
        .pop      (job_pop),
        .head     (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    fwcp_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_job),
        .empty       (q_empty),
        .pop         (job_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .packed_byte (packed_byte),
        .run_end     (run_end),
        .stream_end  (stream_end)
    );

endmodule

FILE: verif/fixed_width_code_packer_unit_tb.sv
`timescale 1ns / 1ps
// Testbench of fixed_width_code_packer_unit: directed and random code streams are packed
// by a local MSB-first bit predictor and every output byte is checked field by field.
// Depends on fwcp_pkg and the packer RTL.
module fixed_width_code_packer_unit_tb;

    typedef struct {
        logic [fwcp_pkg::CODE_W-1:0] value;
        logic                        last;
        bit                          drain_first;
    } code_req_t;

    typedef struct {
        logic [fwcp_pkg::BYTE_W-1:0] value;
        logic                        run_end;
        logic                        stream_end;
    } packed_out_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [fwcp_pkg::WIDTH_W-1:0]   code_width = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [fwcp_pkg::CODE_W-1:0]    code = '0;
    logic                           final_code = 1'b0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [fwcp_pkg::BYTE_W-1:0]    packed_byte;
    logic                           run_end;
    logic                           stream_end;

    code_req_t                      code_queue[$];
    packed_out_t                    awaited_bytes[$];
    code_req_t                      next_req;
    packed_out_t                    want;

    logic [fwcp_pkg::WIDTH_W-1:0]   width_reg = fwcp_pkg::WIDTH_RESET;
    logic [fwcp_pkg::PEND_W-1:0]    held_bits = '0;
    logic [fwcp_pkg::PCOUNT_W-1:0]  held_count = '0;

    bit                             in_fire = 1'b0;
    bit                             calm = 1'b0;
    int                             gap_left = 0;
    int                             stall_left = 0;
    int                             free_left = 0;
    int                             errors = 0;

    fixed_width_code_packer_unit DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .code_width (code_width),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .code       (code),
        .final_code (final_code),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .packed_byte(packed_byte),
        .run_end    (run_end),
        .stream_end (stream_end)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [fwcp_pkg::CODE_W-1:0] random_code();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 255);
            default: return $urandom();
        endcase
    endfunction

    function automatic void pack_code(input logic [fwcp_pkg::CODE_W-1:0] value,
                                      input logic last);
        int unsigned w;
        int unsigned total;
        int unsigned rem;
        int unsigned n_full;
        int unsigned k;
        logic [63:0] acc;
        packed_out_t rec;
        w = 32'(width_reg);
        if (w > fwcp_pkg::MAX_CODE_WIDTH)
            w = fwcp_pkg::MAX_CODE_WIDTH;
        if (w > fwcp_pkg::CODE_W)
            w = fwcp_pkg::CODE_W;
        total = 32'(held_count);
        acc = 64'(held_bits) & ((64'd1 << total) - 64'd1);
        acc = (acc << w) | (64'(value) & ((64'd1 << w) - 64'd1));
        total += w;
        n_full = total / 8;
        rem = total % 8;
        for (k = 0; k < n_full; k++)
        begin
            rec.value = 8'(acc >> (total - 8 * (k + 1)));
            rec.run_end = (k == n_full - 1) && !(last && rem != 0);
            rec.stream_end = rec.run_end && last;
            awaited_bytes.insert(awaited_bytes.size(), rec);
        end
        if (last && rem != 0)
        begin
            rec.value = 8'(acc << (8 - rem));
            rec.run_end = 1'b1;
            rec.stream_end = 1'b1;
            awaited_bytes.insert(awaited_bytes.size(), rec);
        end
        if (last)
        begin
            held_bits = '0;
            held_count = '0;
        end
        else
        begin
            held_bits = 7'(acc & ((64'd1 << rem) - 64'd1));
            held_count = 3'(rem);
        end
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got_v,
                                   input int unsigned want_v);
        $display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", what, got_v, want_v, $realtime);
        errors++;
    endtask

    task automatic push_code(input logic [fwcp_pkg::CODE_W-1:0] value, input logic last,
                             input bit drain_first = 1'b0);
        code_req_t req;
        req.value = value;
        req.last = last;
        req.drain_first = drain_first;
        code_queue.insert(code_queue.size(), req);
    endtask

    task automatic settle();
        do
            @(posedge clk);
        while (code_queue.size() != 0 || in_valid || awaited_bytes.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_width(input logic [fwcp_pkg::WIDTH_W-1:0] w);
        @(negedge clk);
        cfg_valid <= 1'b1;
        code_width <= w;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_streams(input int count);
        int added;
        int len;
        int k;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                push_code(random_code(), 1'($urandom_range(0, 1)), $urandom_range(0, 24) == 0);
                added++;
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++)
                    push_code(random_code(), k == len - 1, $urandom_range(0, 24) == 0);
                added += len;
            end
        end
        settle();
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_fire)
        begin
            if (gap_left > 0 && !calm)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (code_queue.size() != 0
                     && !(code_queue[0].drain_first && awaited_bytes.size() != 0))
            begin
                next_req = code_queue.pop_front();
                in_valid <= 1'b1;
                code <= next_req.value;
                final_code <= next_req.last;
                gap_left = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output back-pressure
    always @(negedge clk)
    begin
        if (!rst_n || calm)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (free_left > 0)
        begin
            free_left = free_left - 1;
            out_stall <= 1'b0;
        end
        else
        begin
            stall_left = pick_gap();
            free_left = $urandom_range(0, 12);
            out_stall <= 1'b0;
        end
    end

    // monitor: predict on accepted requests, check accepted bytes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire = in_valid && !in_stall;
            if (cfg_valid && cfg_ready)
                width_reg = code_width;
            if (in_fire)
                pack_code(code, final_code);
            if (out_valid && !out_stall)
            begin
                if (awaited_bytes.size() == 0)
                    report_mismatch("byte with none awaited", 32'(packed_byte), 0);
                else
                begin
                    want = awaited_bytes.pop_front();
                    if (packed_byte !== want.value)
                        report_mismatch("packed_byte", 32'(packed_byte), 32'(want.value));
                    if (run_end !== want.run_end)
                        report_mismatch("run_end", 32'(run_end), 32'(want.run_end));
                    if (stream_end !== want.stream_end)
                        report_mismatch("stream_end", 32'(stream_end),
                                        32'(want.stream_end));
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_code(32'h0000_0FFF, 1'b0);
        push_code(32'hFFFF_FABC, 1'b1);
        settle();
        write_width(6'd32);
        push_code(32'hFFFF_FFFF, 1'b0, 1'b1);
        push_code(32'h0000_0000, 1'b0);
        push_code(32'h8000_0001, 1'b1);
        settle();
        write_width(6'd1);
        push_code(32'h0000_0001, 1'b0);
        push_code(32'h0000_0000, 1'b0);
        push_code(32'hFFFF_FFFF, 1'b1);
        settle();
        write_width(6'd0);
        push_code(32'hFFFF_FFFF, 1'b0);
        push_code(32'hFFFF_FFFF, 1'b1);
        settle();
        write_width(6'd3);
        push_code(32'h0000_0005, 1'b0);
        settle();
        write_width(6'd0);
        push_code(32'h0000_0000, 1'b1);
        settle();
        write_width(6'd7);
        push_code(32'h0000_007F, 1'b0);
        settle();
        write_width(6'd32);
        push_code(32'hA5A5_A5A5, 1'b1);
        settle();
        write_width(6'd63);
        push_code(32'hDEAD_BEEF, 1'b1);
        settle();
        write_width(6'd8);
        push_code(32'h0000_00C3, 1'b1);
        settle();
        write_width(6'd7);
        push_code(32'h0000_0055, 1'b1);
        settle();

        write_width(6'd32);
        random_streams(20);
        write_width(6'd1);
        random_streams(20);
        write_width(6'($urandom_range(2, 31)));
        random_streams(20);
        write_width(6'd0);
        random_streams(10);
        write_width(6'($urandom_range(33, 63)));
        random_streams(20);
        calm = 1'b1;
        write_width(6'($urandom_range(1, 31)));
        random_streams(15);
        calm = 1'b0;
        write_width(6'($urandom_range(1, 31)));
        random_streams(15);

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/fwcp_pkg.sv
rtl/core/fwcp_front.sv
rtl/core/fwcp_queue.sv
rtl/core/fwcp_back.sv
rtl/core/fixed_width_code_packer_unit.sv
verif/fixed_width_code_packer_unit_tb.sv
